// ===== hw/rtl/lcr_pkg.sv =====
// Shared types and constants for the LCD column/row driver.
`timescale 1ns / 1ps

package lcr_pkg;

    // Port access codes
    typedef enum logic [1:0] {
        ACT_CMD_WRITE   = 2'd0,
        ACT_STATUS_READ = 2'd1,
        ACT_DATA_WRITE  = 2'd2,
        ACT_DATA_READ   = 2'd3
    } lcr_action_t;

    // Cursor counter modes: bit 1 column/row, bit 0 up/down
    typedef enum logic [1:0] {
        CNT_ROW_DOWN = 2'd0,
        CNT_ROW_UP   = 2'd1,
        CNT_COL_DOWN = 2'd2,
        CNT_COL_UP   = 2'd3
    } lcr_count_t;

    typedef struct packed {
        lcr_action_t action;
        logic [7:0]  write_byte;
    } lcr_in_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       display_enabled;
        logic [5:0] contrast_level;
        logic [5:0] row_offset;
    } lcr_out_t;

    // Command decode masks and patterns
    localparam logic [7:0] MASK_1BIT    = 8'hFE;
    localparam logic [7:0] MASK_2BIT    = 8'hFC;
    localparam logic [7:0] MASK_3BIT    = 8'hE0;
    localparam logic [7:0] MASK_2HI     = 8'hC0;
    localparam logic [7:0] PAT_DISPLAY  = 8'h02;
    localparam logic [7:0] PAT_WORDLEN  = 8'h00;
    localparam logic [7:0] PAT_COUNTER  = 8'h04;
    localparam logic [7:0] PAT_TEST     = 8'h00;
    localparam logic [7:0] PAT_COLUMN   = 8'h20;
    localparam logic [7:0] PAT_ZROW     = 8'h40;
    localparam logic [7:0] PAT_ROW      = 8'h80;

    // Six-bit word handling
    localparam logic [15:0] MASK6       = 16'h003F;
    localparam logic [3:0]  SHIFT_BASE  = 4'd10;

    // Column counting bounds
    localparam logic [5:0] COL_WRAP8    = 6'd15;
    localparam logic [5:0] COL_WRAP6    = 6'd19;
    localparam logic [4:0] COL_LAST8    = 5'd14;
    localparam logic [4:0] COL_LAST6    = 5'd18;

    // Reset values
    localparam logic [5:0] CONTRAST_RST = 6'd32;

endpackage

// ===== hw/rtl/lcd_column_row_driver.sv =====
// Top level: LCD column/row driver with command/data ports over display RAM.
// Result strobe (done) comes in the cycle after an item is accepted; no stall.
// Busy stays low for commands, status reads and 8-bit data writes; 8-bit data
// reads pass through S_LAST and 6-bit reads and writes through S_SECOND and
// S_LAST, set by the one read and one write port of the display RAM (6-bit
// words span 2 bytes). After reset a clearing pass zeroes all ROWS*ROW_BYTES
// bytes (1024 by default) with busy high; registers take reset values at once.
`timescale 1ns / 1ps

module lcd_column_row_driver
    import lcr_pkg::*;
#(
    parameter int ROWS      = 64,
    parameter int ROW_BYTES = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  lcr_in_t  access,
    output logic     busy,
    output logic     done,
    output lcr_out_t result
);

    localparam int DEPTH = ROWS * ROW_BYTES;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = (ROWS > 64) ? $clog2(ROWS) : 6;
    localparam logic [RW:0]   ROWS_X   = (RW + 1)'(ROWS);
    localparam logic [RW-1:0] ROW_TOP  = RW'(ROWS - 1);
    localparam logic [AW-1:0] ADDR_TOP = AW'(DEPTH - 1);
    localparam int ROW_RED_STEPS = 7;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SECOND,
        S_LAST
    } state_t;

    state_t      state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [RW-1:0] row_reg, row_next;
    logic [4:0]  col_reg, col_next;
    logic [5:0]  zrow_reg, zrow_next;
    logic [5:0]  contrast_reg, contrast_next;
    logic        disp_on_reg, disp_on_next;
    logic        eight_reg, eight_next;
    lcr_count_t  count_reg, count_next;
    logic [7:0]  latch_reg, latch_next;
    logic        done_reg, done_next;
    lcr_out_t    result_reg, result_next;
    // per-item working registers
    logic        op_write_reg, op_write_next;
    logic        op_eight_reg, op_eight_next;
    logic [AW-1:0] addr0_reg, addr0_next;
    logic [AW-1:0] addr1_reg, addr1_next;
    logic [3:0]  shift_reg, shift_next;
    logic [5:0]  wb6_reg, wb6_next;
    logic [7:0]  hi_reg, hi_next;

    logic          accept;
    logic [AW-1:0] cur_addr0;
    logic [AW-1:0] cur_addr1;
    logic [3:0]    cur_shift;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [15:0]   data16;
    logic [15:0]   keep16;
    logic [15:0]   pair16;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // Address of the byte(s) under the cursor
    lcr_addr #(
        .ROWS      (ROWS),
        .ROW_BYTES (ROW_BYTES)
    ) u_addr (
        .row   (row_reg),
        .col   (col_reg),
        .eight (eight_reg),
        .addr0 (cur_addr0),
        .addr1 (cur_addr1),
        .shift (cur_shift)
    );

    lcr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Six-bit merge and extract
    assign data16 = {10'd0, wb6_reg} << shift_reg;
    assign keep16 = ~(MASK6 << shift_reg);
    assign pair16 = {hi_reg, ram_rdata};

    // Next-state logic
    always_comb
    begin
        logic [RW:0] row_red;
        logic [5:0]  col_inc;
        logic [7:0]  wb;

        state_next    = state_reg;
        clr_next      = clr_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        zrow_next     = zrow_reg;
        contrast_next = contrast_reg;
        disp_on_next  = disp_on_reg;
        eight_next    = eight_reg;
        count_next    = count_reg;
        latch_next    = latch_reg;
        done_next     = accept;
        result_next   = result_reg;
        op_write_next = op_write_reg;
        op_eight_next = op_eight_reg;
        addr0_next    = addr0_reg;
        addr1_next    = addr1_reg;
        shift_next    = shift_reg;
        wb6_next      = wb6_reg;
        hi_next       = hi_reg;

        ram_we    = 1'b0;
        ram_waddr = cur_addr0;
        ram_wdata = access.write_byte;
        ram_raddr = cur_addr0;

        wb       = access.write_byte;
        row_red  = (RW + 1)'(wb[5:0]);
        col_inc  = {1'b0, col_reg} + 6'd1;
        for (int i = 0; i < ROW_RED_STEPS; i++)
        begin
            if (row_red >= ROWS_X)
            begin
                row_red = row_red - ROWS_X;
            end
        end

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = 8'd0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == ADDR_TOP)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.read_byte = 8'd0;
                    op_write_next = (access.action == ACT_DATA_WRITE);
                    op_eight_next = eight_reg;
                    addr0_next    = cur_addr0;
                    addr1_next    = cur_addr1;
                    shift_next    = cur_shift;
                    wb6_next      = wb[5:0];

                    case (access.action)
                        ACT_CMD_WRITE:
                        begin
                            if ((wb & MASK_1BIT) == PAT_DISPLAY)
                            begin
                                disp_on_next = wb[0];
                            end
                            else if ((wb & MASK_1BIT) == PAT_WORDLEN)
                            begin
                                eight_next = wb[0];
                            end
                            else if ((wb & MASK_2BIT) == PAT_COUNTER)
                            begin
                                count_next = lcr_count_t'(wb[1:0]);
                            end
                            else if ((wb & MASK_3BIT) == PAT_TEST)
                            begin
                                // test and op-amp controls: no effect
                            end
                            else if ((wb & MASK_3BIT) == PAT_COLUMN)
                            begin
                                col_next = wb[4:0];
                            end
                            else if ((wb & MASK_2HI) == PAT_ZROW)
                            begin
                                zrow_next = wb[5:0];
                            end
                            else if ((wb & MASK_2HI) == PAT_ROW)
                            begin
                                row_next = row_red[RW-1:0];
                            end
                            else
                            begin
                                contrast_next = wb[5:0];
                            end
                        end

                        ACT_STATUS_READ:
                        begin
                            result_next.read_byte = {1'b0, eight_reg, disp_on_reg,
                                                     3'b000, count_reg};
                        end

                        default:
                        begin
                            // data access: RAM read of first byte issued now
                            if (access.action == ACT_DATA_READ)
                            begin
                                result_next.read_byte = latch_reg;
                            end
                            if (eight_reg)
                            begin
                                if (access.action == ACT_DATA_WRITE)
                                begin
                                    ram_we = 1'b1;
                                end
                                else
                                begin
                                    state_next = S_LAST;
                                end
                            end
                            else
                            begin
                                state_next = S_SECOND;
                            end

                            // cursor step
                            case (count_reg)
                                CNT_ROW_DOWN:
                                    row_next = (row_reg == '0) ? ROW_TOP
                                                               : row_reg - RW'(1);
                                CNT_ROW_UP:
                                    row_next = (row_reg == ROW_TOP) ? '0
                                                                    : row_reg + RW'(1);
                                CNT_COL_DOWN:
                                    if (col_reg == 5'd0)
                                    begin
                                        col_next = eight_reg ? COL_LAST8 : COL_LAST6;
                                    end
                                    else
                                    begin
                                        col_next = col_reg - 5'd1;
                                    end
                                default:
                                    if (col_inc >= (eight_reg ? COL_WRAP8 : COL_WRAP6))
                                    begin
                                        col_next = 5'd0;
                                    end
                                    else
                                    begin
                                        col_next = col_inc[4:0];
                                    end
                            endcase
                        end
                    endcase

                    result_next.display_enabled = disp_on_next;
                    result_next.contrast_level  = contrast_next;
                    result_next.row_offset      = zrow_next;
                end
            end

            S_SECOND:
            begin
                // high byte arrives; read the low byte
                hi_next   = ram_rdata;
                ram_raddr = addr1_reg;
                if (op_write_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr0_reg;
                    ram_wdata = (ram_rdata & keep16[15:8]) | data16[15:8];
                end
                state_next = S_LAST;
            end

            S_LAST:
            begin
                if (op_write_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = addr1_reg;
                    ram_wdata = (ram_rdata & keep16[7:0]) | data16[7:0];
                end
                else if (op_eight_reg)
                begin
                    latch_next = ram_rdata;
                end
                else
                begin
                    latch_next = 8'((pair16 >> shift_reg) & MASK6);
                end
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            row_reg      <= '0;
            col_reg      <= 5'd0;
            zrow_reg     <= 6'd0;
            contrast_reg <= CONTRAST_RST;
            disp_on_reg  <= 1'b0;
            eight_reg    <= 1'b1;
            count_reg    <= CNT_COL_UP;
            latch_reg    <= 8'd0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
            op_write_reg <= 1'b0;
            op_eight_reg <= 1'b1;
            addr0_reg    <= '0;
            addr1_reg    <= '0;
            shift_reg    <= 4'd0;
            wb6_reg      <= 6'd0;
            hi_reg       <= 8'd0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            zrow_reg     <= zrow_next;
            contrast_reg <= contrast_next;
            disp_on_reg  <= disp_on_next;
            eight_reg    <= eight_next;
            count_reg    <= count_next;
            latch_reg    <= latch_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
            op_write_reg <= op_write_next;
            op_eight_reg <= op_eight_next;
            addr0_reg    <= addr0_next;
            addr1_reg    <= addr1_next;
            shift_reg    <= shift_next;
            wb6_reg      <= wb6_next;
            hi_reg       <= hi_next;
        end
    end

    // Checks
    a_done_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result strobe without an accepted item");

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, row_reg} < ROWS_X)
        else $error("row pointer out of range");

    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !done_reg)
        else $error("result during RAM clearing pass");

    a_pair_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LAST && op_write_reg) |-> (ram_waddr != $past(ram_waddr)))
        else $error("6-bit write hit the same byte twice");

endmodule

// ===== hw/rtl/lcr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/lcr_addr.sv =====
// Cursor to display RAM address mapping for 8-bit and 6-bit words.
`timescale 1ns / 1ps

module lcr_addr
    import lcr_pkg::*;
#(
    parameter int ROWS      = 64,
    parameter int ROW_BYTES = 16
) (
    input  logic [((ROWS > 64) ? $clog2(ROWS) : 6)-1:0] row,
    input  logic [4:0]                                 col,
    input  logic                                       eight,
    output logic [$clog2(ROWS*ROW_BYTES)-1:0]          addr0,
    output logic [$clog2(ROWS*ROW_BYTES)-1:0]          addr1,
    output logic [3:0]                                 shift
);

    localparam int AW = $clog2(ROWS * ROW_BYTES);
    localparam int CW = $clog2(ROW_BYTES);
    localparam logic [5:0]    RB_X   = 6'(ROW_BYTES);
    localparam logic [CW-1:0] RB_TOP = CW'(ROW_BYTES - 1);

    logic [7:0]    bitpos;
    logic [4:0]    byte_sel;
    logic [5:0]    byte_red;
    logic [CW-1:0] col0;
    logic [CW-1:0] col1;
    logic [AW-1:0] row_base;

    // Bit position of a 6-bit word: col * 6
    assign bitpos   = {1'b0, col, 2'b00} + {2'b00, col, 1'b0};
    assign byte_sel = eight ? col : bitpos[7:3];

    // Byte column modulo the row length (value stays below twice it)
    assign byte_red = ({1'b0, byte_sel} >= RB_X) ? ({1'b0, byte_sel} - RB_X)
                                                 : {1'b0, byte_sel};
    assign col0     = byte_red[CW-1:0];
    assign col1     = (col0 == RB_TOP) ? '0 : col0 + CW'(1);

    // Row base and byte addresses
    assign row_base = AW'(row) * AW'(ROW_BYTES);
    assign addr0    = row_base + AW'(col0);
    assign addr1    = row_base + AW'(col1);
    assign shift    = SHIFT_BASE - {1'b0, bitpos[2:0]};

endmodule
